### design/cvsr_pkg.sv
`default_nettype none
package cvsr_pkg;

    localparam int SLOT_BITS         = 12;
    localparam int TABLE_ENTRIES     = 1 << SLOT_BITS;
    localparam int VERTEX_INDEX_BITS = 24;
    localparam int CHART_BITS        = 16;
    localparam int KEY_BITS          = VERTEX_INDEX_BITS + CHART_BITS;
    localparam int OUT_INDEX_BITS    = 12;
    localparam int WORD_BITS         = 1 + KEY_BITS + SLOT_BITS;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic clr_step;
        logic probe_next;
        logic insert;
        logic emit_hit;
        logic emit_full;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic mesh;
        logic clr_done;
        logic valid;
        logic match;
        logic last_probe;
        logic full;
    } t_status;

    // xor fold of the key into a slot number
    function automatic logic [SLOT_BITS-1:0] hash_slot(input logic [KEY_BITS-1:0] key);
        logic [SLOT_BITS-1:0] h;
        h = '0;
        for (int i = 0; i < KEY_BITS; i++) begin
            h[i % SLOT_BITS] = h[i % SLOT_BITS] ^ key[i];
        end
        return h;
    endfunction

endpackage
`default_nettype wire

### design/chart_vertex_split_remap.sv
// a request is loaded, its table slot is read and compared, and the result strobe is registered;
// each extra probe repeats the read and compare; a mesh start request adds the table clearing
// sweep and one more table read. One request at a time: busy until the result is issued, as
// the single-port table read and compare loop serves one request
// reset: synchronous, runs the table clearing sweep with busy high; no stall on results
`default_nettype none
module chart_vertex_split_remap (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata,
    input  wire         i_start,
    output logic        o_busy,
    input  wire         i_mesh_start,
    input  wire [23:0]  i_vertex_index,
    input  wire [15:0]  i_chart_id,
    input  wire [31:0]  i_corner_u,
    input  wire [31:0]  i_corner_v,
    output logic        o_strobe,
    output logic [11:0] o_new_index,
    output logic        o_created,
    output logic [23:0] o_source_vertex,
    output logic [31:0] o_out_u,
    output logic [31:0] o_out_v,
    output logic        o_table_full
);

    cvsr_pkg::t_cmd    cmd;
    cvsr_pkg::t_status status;

    // controller
    cvsr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    // table and result datapath
    cvsr_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_mesh_start    (i_mesh_start),
        .i_vertex_index  (i_vertex_index),
        .i_chart_id      (i_chart_id),
        .i_corner_u      (i_corner_u),
        .i_corner_v      (i_corner_v),
        .o_strobe        (o_strobe),
        .o_new_index     (o_new_index),
        .o_created       (o_created),
        .o_source_vertex (o_source_vertex),
        .o_out_u         (o_out_u),
        .o_out_v         (o_out_v),
        .o_table_full    (o_table_full)
    );

endmodule
`default_nettype wire

### design/cvsr_ctrl.sv
`default_nettype none
module cvsr_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire cvsr_pkg::t_status i_status,
    output cvsr_pkg::t_cmd      o_cmd,
    output logic                o_busy
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CLEAR = 4'b0010,
        S_READ  = 4'b0100,
        S_CMP   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_job, n_job;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_job      = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_done) begin
                    n_state = r_job ? S_READ : S_IDLE;
                end
            end
            S_READ: begin
                // mesh start clears the table before the lookup
                if (i_status.mesh) begin
                    n_state = S_CLEAR;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_IDLE;
                n_job   = 1'b0;
                if (!i_status.valid) begin
                    if (i_status.full) o_cmd.emit_full = 1'b1;
                    else               o_cmd.insert    = 1'b1;
                end else if (i_status.match) begin
                    o_cmd.emit_hit = 1'b1;
                end else if (i_status.last_probe) begin
                    o_cmd.emit_full = 1'b1;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = S_READ;
                    n_job            = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_job   = 1'b0;
            end
        endcase
    end

    // state registers, clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_job   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
        end
    end

    // checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy) else $error("busy not raised after request");
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.insert |-> !i_status.full) else $error("insert into full table");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.insert, o_cmd.emit_hit, o_cmd.emit_full}))
        else $error("more than one result");

endmodule
`default_nettype wire

### design/cvsr_datapath.sv
`default_nettype none
module cvsr_datapath (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire cvsr_pkg::t_cmd i_cmd,
    output cvsr_pkg::t_status   o_status,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_wdata,
    input  wire                 i_mesh_start,
    input  wire [23:0]          i_vertex_index,
    input  wire [15:0]          i_chart_id,
    input  wire [31:0]          i_corner_u,
    input  wire [31:0]          i_corner_v,
    output logic                o_strobe,
    output logic [11:0]         o_new_index,
    output logic                o_created,
    output logic [23:0]         o_source_vertex,
    output logic [31:0]         o_out_u,
    output logic [31:0]         o_out_v,
    output logic                o_table_full
);

    localparam int SB = cvsr_pkg::SLOT_BITS;
    localparam int KB = cvsr_pkg::KEY_BITS;
    localparam int WB = cvsr_pkg::WORD_BITS;
    localparam int OB = cvsr_pkg::OUT_INDEX_BITS;
    localparam int VB = cvsr_pkg::VERTEX_INDEX_BITS;

    logic [WB-1:0] mem [cvsr_pkg::TABLE_ENTRIES];
    logic [WB-1:0] r_rdata;

    logic          r_uv;
    logic          r_mesh;
    logic [KB-1:0] r_key;
    logic [23:0]   r_vtx;
    logic [31:0]   r_u, r_v;
    logic [SB-1:0] r_slot;
    logic [SB:0]   r_probes;
    logic [SB:0]   r_next;
    logic [SB-1:0] r_clr;

    logic [KB-1:0] in_key;
    logic          we;
    logic [SB-1:0] waddr;
    logic [WB-1:0] wdata;

    assign in_key = {i_chart_id, i_vertex_index[VB-1:0]};

    // status from the registered read word and the probe and clear counters
    assign o_status.mesh       = r_mesh;
    assign o_status.clr_done   = (r_clr == SB'(cvsr_pkg::TABLE_ENTRIES - 1));
    assign o_status.valid      = r_rdata[WB-1];
    assign o_status.match      = (r_rdata[WB-2 -: KB] == r_key);
    assign o_status.last_probe = (r_probes == (SB+1)'(cvsr_pkg::TABLE_ENTRIES - 1));
    assign o_status.full       = (r_next == (SB+1)'(cvsr_pkg::TABLE_ENTRIES));

    // write port: clearing sweep or insert
    always_comb begin
        we    = i_cmd.clr_step || i_cmd.insert;
        waddr = i_cmd.clr_step ? r_clr : r_slot;
        wdata = i_cmd.clr_step ? '0 : {1'b1, r_key, r_next[SB-1:0]};
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rdata <= mem[r_slot];
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_uv <= 1'b1;
        else if (i_cfg_we) r_uv <= i_cfg_wdata;
    end

    // request capture and probe state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_next <= '0;
            r_mesh <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_mesh   <= i_mesh_start;
                r_key    <= in_key;
                r_vtx    <= i_vertex_index;
                r_u      <= i_corner_u;
                r_v      <= i_corner_v;
                r_slot   <= cvsr_pkg::hash_slot(in_key);
                r_probes <= '0;
            end
            if (i_cmd.clr_step) begin
                r_clr  <= r_clr + 1'b1;
                r_next <= '0;
                r_mesh <= 1'b0;
            end
            if (i_cmd.probe_next) begin
                r_slot   <= r_slot + 1'b1;
                r_probes <= r_probes + 1'b1;
            end
            if (i_cmd.insert) r_next <= r_next + 1'b1;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.insert || i_cmd.emit_hit || i_cmd.emit_full;
        end
        o_new_index     <= i_cmd.insert   ? r_next[OB-1:0] :
                           i_cmd.emit_hit ? r_rdata[OB-1:0] : '0;
        o_created       <= i_cmd.insert;
        o_source_vertex <= i_cmd.insert ? r_vtx : '0;
        o_out_u         <= (i_cmd.insert && r_uv) ? r_u : 32'd0;
        o_out_v         <= (i_cmd.insert && r_uv) ? r_v : 32'd0;
        o_table_full    <= i_cmd.emit_full;
    end

endmodule
`default_nettype wire

### bench/tb_chart_vertex_split_remap.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_chart_vertex_split_remap;

    typedef struct {
        logic [11:0] new_index;
        logic        created;
        logic [23:0] source_vertex;
        logic [31:0] out_u;
        logic [31:0] out_v;
        logic        table_full;
    } t_remap;

    // tracks the pair table and checks every strobed result in order
    class remap_scoreboard;
        int unsigned          pair_map [logic [cvsr_pkg::KEY_BITS-1:0]];
        int unsigned          dense_count;
        bit                   uv_on;
        t_remap               pending [$];
        int unsigned          errors;
        int unsigned          checked;
        int unsigned          creations;
        int unsigned          overflows;

        function new();
            uv_on = 1'b1;
            dense_count = 0;
            errors = 0;
            checked = 0;
            creations = 0;
            overflows = 0;
        endfunction

        // predict the result of an accepted request
        function void note_request(input logic mesh, input logic [23:0] vtx,
                                   input logic [15:0] chart, input logic [31:0] u,
                                   input logic [31:0] v);
            logic [cvsr_pkg::KEY_BITS-1:0] key;
            t_remap r;
            key = {chart, vtx};
            if (mesh) begin
                pair_map.delete();
                dense_count = 0;
            end
            r = '{12'd0, 1'b0, 24'd0, 32'd0, 32'd0, 1'b0};
            if (pair_map.exists(key)) begin
                r.new_index = pair_map[key][11:0];
            end else if (dense_count >= cvsr_pkg::TABLE_ENTRIES) begin
                r.table_full = 1'b1;
                overflows++;
            end else begin
                pair_map[key] = dense_count;
                r.new_index = dense_count[11:0];
                r.created = 1'b1;
                r.source_vertex = vtx;
                if (uv_on) begin
                    r.out_u = u;
                    r.out_v = v;
                end
                dense_count++;
                creations++;
            end
            pending = {pending, r};
        endfunction

        // compare a result against the oldest prediction
        function void check_result(input t_remap got);
            t_remap want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result index=%0d", $time, got.new_index);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.new_index !== got.new_index) begin
                $display("%0t: new_index exp %0d got %0d", $time, want.new_index,
                         got.new_index);
                errors++;
            end
            if (want.created !== got.created) begin
                $display("%0t: created exp %0b got %0b", $time, want.created, got.created);
                errors++;
            end
            if (want.source_vertex !== got.source_vertex) begin
                $display("%0t: source_vertex exp %h got %h", $time, want.source_vertex,
                         got.source_vertex);
                errors++;
            end
            if (want.out_u !== got.out_u) begin
                $display("%0t: out_u exp %h got %h", $time, want.out_u, got.out_u);
                errors++;
            end
            if (want.out_v !== got.out_v) begin
                $display("%0t: out_v exp %h got %h", $time, want.out_v, got.out_v);
                errors++;
            end
            if (want.table_full !== got.table_full) begin
                $display("%0t: table_full exp %0b got %0b", $time, want.table_full,
                         got.table_full);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_start;
    logic        o_busy;
    logic        i_mesh_start;
    logic [23:0] i_vertex_index;
    logic [15:0] i_chart_id;
    logic [31:0] i_corner_u;
    logic [31:0] i_corner_v;
    logic        o_strobe;
    logic [11:0] o_new_index;
    logic        o_created;
    logic [23:0] o_source_vertex;
    logic [31:0] o_out_u;
    logic [31:0] o_out_v;
    logic        o_table_full;

    remap_scoreboard remap_sb;
    bit              idle_on;
    int unsigned     requests;
    logic [23:0]     vtx_pool [16];

    chart_vertex_split_remap i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_mesh_start    (i_mesh_start),
        .i_vertex_index  (i_vertex_index),
        .i_chart_id      (i_chart_id),
        .i_corner_u      (i_corner_u),
        .i_corner_v      (i_corner_v),
        .o_strobe        (o_strobe),
        .o_new_index     (o_new_index),
        .o_created       (o_created),
        .o_source_vertex (o_source_vertex),
        .o_out_u         (o_out_u),
        .o_out_v         (o_out_v),
        .o_table_full    (o_table_full)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            remap_sb.check_result('{o_new_index, o_created, o_source_vertex, o_out_u,
                                   o_out_v, o_table_full});
        end
    end

    // one corner request, held until taken
    task automatic send_corner(input logic mesh, input logic [23:0] vtx,
                               input logic [15:0] chart, input logic [31:0] u,
                               input logic [31:0] v);
        i_start        <= 1'b1;
        i_mesh_start   <= mesh;
        i_vertex_index <= vtx;
        i_chart_id     <= chart;
        i_corner_u     <= u;
        i_corner_v     <= v;
        do @(posedge i_clk); while (o_busy);
        remap_sb.note_request(mesh, vtx, chart, u, v);
        requests++;
        // random idle burst on the request side
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // wait for all predicted results, then let the block settle
    task automatic drain();
        i_start <= 1'b0;
        while (remap_sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_uv(input logic val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        remap_sb.uv_on = val;
        @(posedge i_clk);
    endtask

    // random corner drawn mostly from a small pool so pairs repeat
    task automatic random_corner();
        logic [23:0] vtx;
        logic [15:0] chart;
        logic        mesh;
        mesh = ($urandom_range(0, 19) == 0);
        if ($urandom_range(0, 4) == 0) begin
            vtx   = 24'($urandom());
            chart = 16'($urandom());
        end else begin
            vtx   = vtx_pool[$urandom_range(0, 15)];
            chart = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 3));
        end
        send_corner(mesh, vtx, chart, $urandom(), $urandom());
    endtask

    initial begin
        remap_sb       = new();
        idle_on        = 1'b1;
        requests       = 0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 1'b0;
        i_start        = 1'b0;
        i_mesh_start   = 1'b0;
        i_vertex_index = '0;
        i_chart_id     = '0;
        i_corner_u     = '0;
        i_corner_v     = '0;
        foreach (vtx_pool[k]) vtx_pool[k] = 24'($urandom());
        vtx_pool[0] = 24'h000000;
        vtx_pool[1] = 24'hFFFFFF;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, repeats, seam split, mesh restart
        send_corner(1'b0, 24'h000000, 16'h0000, 32'h00000000, 32'hFFFFFFFF);
        send_corner(1'b0, 24'hFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'h00000000);
        send_corner(1'b0, 24'h000000, 16'h0000, 32'h12345678, 32'h9ABCDEF0);
        send_corner(1'b0, 24'h000000, 16'h0001, 32'h3F800000, 32'h3F000000);
        send_corner(1'b0, 24'hFFFFFF, 16'hFFFF, 32'h0, 32'h0);
        send_corner(1'b0, 24'hA5A5A5, 16'h5A5A, 32'hAAAAAAAA, 32'h55555555);
        send_corner(1'b1, 24'hA5A5A5, 16'h5A5A, 32'h55555555, 32'hAAAAAAAA);
        send_corner(1'b0, 24'h000000, 16'h0000, 32'h1, 32'h2);
        write_uv(1'b0);
        send_corner(1'b0, 24'h5A5A5A, 16'hA5A5, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_corner(1'b0, 24'hA5A5A5, 16'h5A5A, 32'h1, 32'h1);
        send_corner(1'b1, 24'h000001, 16'h8000, 32'hDEADBEEF, 32'hCAFEF00D);
        write_uv(1'b1);

        // fill the table to overflow with no idling
        idle_on = 1'b0;
        send_corner(1'b1, 24'd0, 16'h0F0F, $urandom(), $urandom());
        for (int n = 1; n < cvsr_pkg::TABLE_ENTRIES; n++)
            send_corner(1'b0, 24'(n), 16'h0F0F, $urandom(), $urandom());
        send_corner(1'b0, 24'd4095, 16'h0F0F, 32'h1, 32'h1);
        send_corner(1'b0, 24'd7, 16'h0F0F, 32'h1, 32'h1);
        send_corner(1'b0, 24'hFFFFFF, 16'hFFFF, 32'h1, 32'h1);
        send_corner(1'b0, 24'd4096, 16'h0F0F, 32'h1, 32'h1);
        send_corner(1'b0, 24'd0, 16'h0F0E, 32'h1, 32'h1);
        send_corner(1'b0, 24'd0, 16'h0F0F, 32'h1, 32'h1);
        idle_on = 1'b1;

        // random phases with different uv settings, last one without idling
        send_corner(1'b1, 24'd1, 16'd1, $urandom(), $urandom());
        repeat (250) random_corner();
        write_uv(1'b0);
        repeat (250) random_corner();
        write_uv(1'b1);
        idle_on = 1'b0;
        repeat (250) random_corner();

        drain();
        repeat (20) @(posedge i_clk);
        $display("corners sent %0d, results checked %0d", requests, remap_sb.checked);
        $display("new vertices %0d, overflow results %0d, uv on and off, table filled",
                 remap_sb.creations, remap_sb.overflows);
        if (remap_sb.errors == 0 && remap_sb.pending.size() == 0)
            $display("** chart_vertex_split_remap: PASSED **");
        else
            $display("** chart_vertex_split_remap: FAILED **");
        $finish;
    end

    // watchdog
    initial begin
        #30ms;
        $display("timeout waiting for results");
        $display("** chart_vertex_split_remap: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire

### chart_vertex_split_remap.f
design/cvsr_pkg.sv
design/cvsr_ctrl.sv
design/cvsr_datapath.sv
design/chart_vertex_split_remap.sv
bench/tb_chart_vertex_split_remap.sv
